// ----- rtl/core/morse_timing_decoder_macros.svh -----
// Assertion macros for the Morse timing decoder RTL.
// Depends on nothing; included by the modules that carry assertions.
`ifndef MORSE_TIMING_DECODER_MACROS_SVH
`define MORSE_TIMING_DECODER_MACROS_SVH

`ifndef SYNTH
// Property checked on every clock edge outside reset.
`define MTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Property checked on every clock edge, reset included.
`define MTD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MTD_ASSERT(lbl, prop, msg)
`define MTD_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- rtl/core/mtd_pkg.sv -----
// Shared types, constants and letter table for the Morse timing decoder.
// Depends on nothing; imported by every module of the block.
package mtd_pkg;

  // Element limit default and the widest pattern the limit range allows
  localparam int MAX_ELEMENTS_DEF = 4;
  localparam int PAT_W            = 6;
  localparam int CNT_W            = 3;
  localparam int RUN_W            = 4;
  localparam int LETTER_COUNT     = 26;

  // Result queue
  localparam int RES_DEPTH  = 4;
  localparam int RES_PTR_W  = $clog2(RES_DEPTH);
  localparam int RES_CNT_W  = $clog2(RES_DEPTH + 1);

  localparam logic [RUN_W-1:0] RUN_MAX = '1;

  // Result codes
  localparam logic [4:0] CODE_UNKNOWN = 5'd26;
  localparam logic [4:0] CODE_SPACE   = 5'd27;
  localparam logic [4:0] CODE_EOL     = 5'd28;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_DASH_UNITS       = 2'd0,
    REG_LETTER_GAP_UNITS = 2'd1,
    REG_WORD_GAP_UNITS   = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic key_down;
    logic end_of_message;
  } item_t;

  typedef struct packed {
    logic [4:0] code;
    logic       last_of_run;
  } result_t;

  typedef struct packed {
    logic [2:0] dash_units;
    logic [2:0] letter_gap_units;
    logic [3:0] word_gap_units;
  } cfg_t;

  // Letter assembly state
  typedef struct packed {
    logic [RUN_W-1:0] mark_run;
    logic [RUN_W-1:0] gap_run;
    logic [PAT_W-1:0] pattern;
    logic [CNT_W-1:0] count;
    logic             bad;
    logic             open;
    logic             prev_key_down;
  } dec_state_t;

  // Results of one item, handed to the result queue
  typedef struct packed {
    logic [1:0] num;
    logic [4:0] code0;
    logic [4:0] code1;
  } push_t;

  // Element count and dash bits (first element most significant) of a..z
  localparam logic [CNT_W-1:0] LETTER_LEN [LETTER_COUNT] = '{
    3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
    3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
  };
  localparam logic [PAT_W-1:0] LETTER_BITS [LETTER_COUNT] = '{
    6'd1, 6'd8, 6'd10, 6'd4, 6'd0, 6'd2, 6'd6, 6'd0, 6'd0, 6'd7, 6'd5, 6'd4, 6'd3,
    6'd2, 6'd7, 6'd6, 6'd13, 6'd2, 6'd0, 6'd1, 6'd1, 6'd1, 6'd3, 6'd9, 6'd11, 6'd12
  };

  // Table match; first hit wins, no hit is the unknown code
  function automatic logic [4:0] letter_lookup(logic [CNT_W-1:0] count,
                                               logic [PAT_W-1:0] pattern);
    logic [4:0] code;
    code = CODE_UNKNOWN;
    for (int i = LETTER_COUNT - 1; i >= 0; i--) begin
      if (LETTER_LEN[i] == count && LETTER_BITS[i] == pattern) begin
        code = 5'(i);
      end
    end
    return code;
  endfunction

endpackage

// ----- rtl/core/mtd_decode.sv -----
// Per-unit run tracking, element packing and letter decode.
// Depends on mtd_pkg and the assertion macros header.
`include "morse_timing_decoder_macros.svh"

module mtd_decode import mtd_pkg::*; #(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic  clk,
  input  logic  rst,
  input  logic  fire,
  input  item_t item,
  input  cfg_t  cfg,
  output push_t push
);

  dec_state_t st;
  dec_state_t st_next;
  logic [1:0] num;
  logic [4:0] codes [2];

  // Close the current mark: dot, dash or a bad length
  function automatic dec_state_t finish_mark(dec_state_t s, logic [2:0] dash);
    logic bit_v;
    bit_v = 1'b0;
    if (s.mark_run == RUN_W'(1)) begin
      bit_v = 1'b0;
    end else if (s.mark_run == {1'b0, dash}) begin
      bit_v = 1'b1;
    end else begin
      s.bad = 1'b1;
    end
    if (s.count >= CNT_W'(MAX_ELEMENTS)) begin
      s.bad = 1'b1;
    end else begin
      s.pattern = {s.pattern[PAT_W-2:0], bit_v};
      s.count   = s.count + CNT_W'(1);
    end
    s.mark_run = '0;
    return s;
  endfunction

  // One time unit of decode
  always_comb begin
    st_next  = st;
    num      = 2'd0;
    codes[0] = '0;
    codes[1] = '0;
    if (item.key_down) begin
      if (!st.prev_key_down) begin
        if (st.open && st.gap_run >= RUN_W'(2)) begin
          st_next.bad = 1'b1;
        end
        st_next.open = 1'b1;
      end
      st_next.gap_run = '0;
      if (st.mark_run < RUN_MAX) begin
        st_next.mark_run = st.mark_run + RUN_W'(1);
      end
    end else begin
      if (st.prev_key_down) begin
        st_next = finish_mark(st_next, cfg.dash_units);
      end
      if (st_next.gap_run < RUN_MAX) begin
        st_next.gap_run = st_next.gap_run + RUN_W'(1);
      end
      // letter ends on the letter gap or the word gap, whichever first
      if (st_next.open && (st_next.gap_run >= {1'b0, cfg.letter_gap_units} ||
                           st_next.gap_run >= cfg.word_gap_units)) begin
        codes[num[0]] = st_next.bad ? CODE_UNKNOWN
                                    : letter_lookup(st_next.count, st_next.pattern);
        num             = num + 2'd1;
        st_next.pattern = '0;
        st_next.count   = '0;
        st_next.bad     = 1'b0;
        st_next.open    = 1'b0;
      end
      if (!item.end_of_message && st_next.gap_run == cfg.word_gap_units) begin
        codes[num[0]] = CODE_SPACE;
        num           = num + 2'd1;
      end
    end
    st_next.prev_key_down = item.key_down;

    // end of message: flush the open letter, mark the line end, start over
    if (item.end_of_message) begin
      if (item.key_down) begin
        st_next = finish_mark(st_next, cfg.dash_units);
      end
      if (st_next.open) begin
        codes[num[0]] = st_next.bad ? CODE_UNKNOWN
                                    : letter_lookup(st_next.count, st_next.pattern);
        num           = num + 2'd1;
      end
      codes[num[0]] = CODE_EOL;
      num           = num + 2'd1;
      st_next       = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (fire) begin
      st <= st_next;
    end
  end

  assign push.num   = fire ? num : 2'd0;
  assign push.code0 = codes[0];
  assign push.code1 = codes[1];

  // A second result is always a space or the line end after a letter
  `MTD_ASSERT(a_second_kind, push.num == 2'd2 |-> (push.code1 == CODE_SPACE ||
    push.code1 == CODE_EOL) && push.code0 <= CODE_UNKNOWN, "bad second result")
  // Line end always clears the letter state
  `MTD_ASSERT(a_eom_clears, fire && item.end_of_message |=> st == '0,
    "state not cleared after end of message")
  // Element count never passes the limit
  `MTD_ASSERT(a_count_limit, st.count <= CNT_W'(MAX_ELEMENTS),
    "element count over limit")

endmodule

// ----- rtl/core/mtd_result_fifo.sv -----
// Small result queue: up to two results pushed, one popped per cycle while ready.
// Depends on mtd_pkg and the assertion macros header.
`include "morse_timing_decoder_macros.svh"

module mtd_result_fifo import mtd_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  push_t   push,
  output logic    room2,
  output logic    result_valid,
  input  logic    result_ready,
  output result_t result
);

  result_t              mem [RES_DEPTH];
  logic [RES_PTR_W-1:0] wr_ptr;
  logic [RES_PTR_W-1:0] rd_ptr;
  logic [RES_CNT_W-1:0] count;
  logic                 pop;

  assign pop          = result_valid && result_ready;
  assign result_valid = count != '0;
  assign result       = mem[rd_ptr];
  assign room2        = count <= RES_CNT_W'(RES_DEPTH - 2);

  // Entry writes; the last pushed result carries the final flag
  always_ff @(posedge clk) begin
    if (push.num != 2'd0) begin
      mem[wr_ptr] <= '{code: push.code0, last_of_run: push.num == 2'd1};
    end
    if (push.num == 2'd2) begin
      mem[wr_ptr + RES_PTR_W'(1)] <= '{code: push.code1, last_of_run: 1'b1};
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + RES_PTR_W'(push.num);
      if (pop) begin
        rd_ptr <= rd_ptr + RES_PTR_W'(1);
      end
      count <= count + RES_CNT_W'(push.num) - RES_CNT_W'(pop);
    end
  end

  `MTD_ASSERT(a_no_overflow, push.num != 2'd0 |-> room2, "push without room")
  `MTD_ASSERT(a_count_track, ##1 count == $past(count) + RES_CNT_W'($past(push.num))
    - RES_CNT_W'($past(pop)), "fill count mismatch")
  // A non-final result always has its partner queued behind it
  `MTD_ASSERT(a_partner_queued, result_valid && !result.last_of_run |->
    count >= RES_CNT_W'(2), "non-final result without partner")

endmodule

// ----- rtl/core/morse_timing_decoder.sv -----
// Morse timing decoder: one keying time unit in, decoded letters out.
//
// Channels (valid/ready):
//   item   : one time unit, key_down (mark or gap) and end_of_message.
//   result : code (0..25 letter, 26 unknown, 27 space, 28 end of line)
//            and last_of_run, set on the final result of a unit.
//   cfg    : register writes, cfg_index 0 dash_units, 1 letter_gap_units,
//            2 word_gap_units; always ready. Write only while idle.
// Each unit passes through the input register, then decode, into the result
// queue. Throughput: one unit per cycle while two queue entries are free;
// a unit that gives two results offers them one after another through
// the single result port of the four-entry queue. item_ready drops while
// the input register is full and fewer than two queue entries are free,
// so a stalled receiver holds back input after at most four pending results.
// Reset clears the letter state, the queue and the registers (3, 3, 7).
// Depends on mtd_pkg, mtd_decode and mtd_result_fifo.
module morse_timing_decoder import mtd_pkg::*; #(
  parameter int MAX_ELEMENTS = MAX_ELEMENTS_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  output logic       item_ready,
  input  item_t      item,
  output logic       result_valid,
  input  logic       result_ready,
  output result_t    result,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_data
);

  cfg_t  cfg;
  item_t item_q;
  logic  item_q_valid;
  logic  room2;
  logic  fire;
  push_t push;

  assign cfg_ready  = 1'b1;
  assign fire       = item_q_valid && room2;
  assign item_ready = !item_q_valid || room2;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '{dash_units: 3'd3, letter_gap_units: 3'd3, word_gap_units: 4'd7};
    end else if (cfg_valid) begin
      case (cfg_reg_t'(cfg_index))
        REG_DASH_UNITS:       cfg.dash_units       <= cfg_data[2:0];
        REG_LETTER_GAP_UNITS: cfg.letter_gap_units <= cfg_data[2:0];
        REG_WORD_GAP_UNITS:   cfg.word_gap_units   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_q_valid <= 1'b0;
    end else if (item_ready) begin
      item_q_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      item_q <= item;
    end
  end

  mtd_decode #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_decode (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (item_q),
    .cfg  (cfg),
    .push (push)
  );

  mtd_result_fifo u_fifo (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .room2        (room2),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
